// ===== hdl/phrh_pkg.sv =====
// ---------------------------------------------------------------------------
// phrh_pkg
// Shared types and constants for the per-second rate history block.
// ---------------------------------------------------------------------------
`default_nettype none

package phrh_pkg;

    localparam int CHANNELS      = 16;
    localparam int HISTORY_DEPTH = 3600;

    localparam int CH_FIELD_W = 4;
    localparam int CH_FIELD_N = 2 ** CH_FIELD_W;
    localparam int NUM_CH     = (CHANNELS < CH_FIELD_N) ? CHANNELS : CH_FIELD_N;
    localparam int CH_IDX_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

    localparam int REQ_W   = 2;
    localparam int TS_W    = 64;
    localparam int AGE_W   = 12;
    localparam int COUNT_W = 32;
    localparam int LEN_W   = 12;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int HELD_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CALC_W = ((HELD_W > AGE_W) ? HELD_W : AGE_W) + 1;
    localparam int MEM_AW = CH_IDX_W + SLOT_W;

    localparam logic [TS_W-1:0] NS_PER_SEC = 64'd1000000000;

    // seconds = ((ns >> 9) * RECIP_MUL) >> 75, exact for every 64-bit ns
    localparam int QUO_W       = 35;
    localparam int MUL_W       = 32;
    localparam int RECIP_PRE   = 9;
    localparam int RECIP_N_W   = TS_W - RECIP_PRE;
    localparam int RECIP_SHIFT = 75;
    localparam int ACC_W       = RECIP_SHIFT + QUO_W;
    localparam logic [RECIP_N_W-1:0] RECIP_MUL = 55'h44B82FA09B5A53;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_EVENT = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req_e;

    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [CH_FIELD_W-1:0] channel;
        logic [TS_W-1:0]       timestamp_ns;
        logic [AGE_W-1:0]      age;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [LEN_W-1:0]   history_length;
        logic               entry_valid;
        logic               new_second;
    } t_out_item;

    typedef struct packed {
        logic            start;
        logic [TS_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } t_div_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_EVAL,
        S_FILL,
        S_PUSH,
        S_INCRD,
        S_READ,
        S_DONE
    } t_seq_state;

endpackage

`default_nettype wire

// ===== hdl/per_second_rate_history_top.sv =====
// ---------------------------------------------------------------------------
// per_second_rate_history_top
// Per-channel history of event counts per second, with an output register.
// ---------------------------------------------------------------------------
// event: the seconds come from the 4-step shared multiplier; a later second
//   within the history first writes a zero entry for each skipped second; a
//   read of an entry that is not held skips the memory read; clear and unused
//   codes give their result without the multiplier or the memory
// throughput: one item at a time, next accepted in the cycle after the result is
//   registered; a held output stalls the sequencer once its result is ready
// reset clears channel state at once; history memory is not cleared
`default_nettype none

module per_second_rate_history_top import phrh_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    logic      seq_busy;
    logic      res_valid;
    t_out_item res;
    logic      res_load;
    t_div_req  div_req;
    t_div_rsp  div_rsp;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data;

    phrh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    phrh_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in_valid),
        .i_item       (i_in_data),
        .o_busy       (seq_busy),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_load),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp)
    );

    assign o_in_stall  = seq_busy;
    assign res_load    = res_valid && (!r_out_valid || !i_out_stall);
    assign n_out_valid = res_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (res_load) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== hdl/phrh_div.sv =====
// ---------------------------------------------------------------------------
// phrh_div
// Nanosecond timestamp to whole seconds by reciprocal multiplication on one
// shared 32x32 multiplier, one partial product per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module phrh_div import phrh_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    t_div_state           r_state, n_state;
    logic [RECIP_N_W-1:0] r_num, n_num;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   mul_p;
    logic [ACC_W-1:0]     addend;

    assign mul_a = r_cnt[1] ? MUL_W'(r_num[RECIP_N_W-1:MUL_W]) : r_num[MUL_W-1:0];
    assign mul_b = r_cnt[0] ? MUL_W'(RECIP_MUL[RECIP_N_W-1:MUL_W])
                            : RECIP_MUL[MUL_W-1:0];
    assign mul_p = mul_a * mul_b;

    always_comb begin
        case (r_cnt)
            DIV_CNT_W'(0): addend = ACC_W'(mul_p);
            DIV_CNT_W'(3): addend = ACC_W'({mul_p, {(2*MUL_W){1'b0}}});
            default:       addend = ACC_W'({mul_p, {MUL_W{1'b0}}});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_num <= n_num;
        r_acc <= n_acc;
    end

    always_comb begin
        n_state        = r_state;
        n_num          = r_num;
        n_acc          = r_acc;
        n_cnt          = r_cnt;
        o_rsp.done     = 1'b0;
        o_rsp.quotient = r_acc[ACC_W-1:RECIP_SHIFT];
        case (r_state)
            DIV_IDLE: begin
                if (i_req.start) begin
                    n_num   = i_req.dividend[TS_W-1:RECIP_PRE];
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_cnt != DIV_CNT_W'(DIV_STEPS)) begin
                    n_acc = r_acc + addend;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    o_rsp.done = 1'b1;
                    n_state    = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DIV_CNT_W'(DIV_STEPS))
        else $error("step count beyond partial products");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == DIV_IDLE))
        else $error("start while a conversion runs");

    a_done_after_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> (r_cnt == DIV_CNT_W'(DIV_STEPS)))
        else $error("done before every partial product");

endmodule

`default_nettype wire

// ===== hdl/phrh_seq.sv =====
// ---------------------------------------------------------------------------
// phrh_seq
// Sequencer with per-channel state and the count history memory.
// ---------------------------------------------------------------------------
`default_nettype none

module phrh_seq import phrh_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_item_valid,
    input  wire t_in_item  i_item,
    output logic           o_busy,
    output logic           o_res_valid,
    output t_out_item      o_res,
    input  wire logic      i_res_ready,
    output t_div_req       o_div_req,
    input  wire t_div_rsp  i_div_rsp
);

    t_seq_state          r_state, n_state;
    t_in_item            r_item;
    logic [CH_IDX_W-1:0] r_ch;
    logic                r_ch_ok;
    logic [QUO_W-1:0]    r_sec, n_sec;
    logic [SLOT_W-1:0]   r_fill, n_fill;
    t_out_item           r_res, n_res;

    logic [SLOT_W-1:0]   r_newest [NUM_CH];
    logic [HELD_W-1:0]   r_held   [NUM_CH];
    logic [QUO_W-1:0]    r_cur    [NUM_CH];
    logic                r_known  [NUM_CH];

    logic [COUNT_W-1:0]  r_mem [2**MEM_AW];
    logic [COUNT_W-1:0]  r_rd_data;

    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [COUNT_W-1:0]  mem_wdata;
    logic [MEM_AW-1:0]   mem_raddr;

    logic                ch_clear, ch_gap, ch_push, ch_set_sec;
    logic [SLOT_W-1:0]   cur_newest, newest_nx;
    logic [HELD_W-1:0]   cur_held, n_held;
    logic [CALC_W-1:0]   age_ext, held_ext, newest_ext, rd_calc;
    logic                rd_hit;
    logic [QUO_W-1:0]    diff;
    logic [COUNT_W-1:0]  inc_val;
    logic                in_ch_ok;

    assign in_ch_ok   = ({1'b0, i_item.channel} < (CH_FIELD_W+1)'(NUM_CH));
    assign cur_newest = r_newest[r_ch];
    assign cur_held   = r_held[r_ch];
    assign newest_nx  = (cur_newest == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : cur_newest + 1'b1;
    assign n_held     = (cur_held < HELD_W'(HISTORY_DEPTH)) ? cur_held + 1'b1 : cur_held;

    assign age_ext    = CALC_W'(r_item.age);
    assign held_ext   = CALC_W'(cur_held);
    assign newest_ext = CALC_W'(cur_newest);
    assign rd_hit     = (age_ext < held_ext);
    assign rd_calc    = (newest_ext >= age_ext) ? newest_ext - age_ext
                      : newest_ext + CALC_W'(HISTORY_DEPTH) - age_ext;

    assign diff    = r_sec - r_cur[r_ch];
    assign inc_val = (r_rd_data == '1) ? r_rd_data : r_rd_data + 1'b1;

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_ch_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_item_valid) begin
                r_ch    <= in_ch_ok ? CH_IDX_W'(i_item.channel) : '0;
                r_ch_ok <= in_ch_ok;
            end
        end
        if (r_state == S_IDLE && i_item_valid) begin
            r_item <= i_item;
        end
        r_sec  <= n_sec;
        r_fill <= n_fill;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ch_clear) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_newest[i] <= '0;
                r_held[i]   <= '0;
                r_cur[i]    <= '0;
                r_known[i]  <= 1'b0;
            end
        end else begin
            if (ch_gap) begin
                r_held[r_ch]   <= '0;
                r_newest[r_ch] <= '0;
            end
            if (ch_push) begin
                r_held[r_ch]   <= n_held;
                r_newest[r_ch] <= newest_nx;
            end
            if (ch_set_sec) begin
                r_cur[r_ch]   <= r_sec;
                r_known[r_ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state            = r_state;
        n_sec              = r_sec;
        n_fill             = r_fill;
        n_res              = r_res;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_item.timestamp_ns;
        mem_we             = 1'b0;
        mem_waddr          = {r_ch, newest_nx};
        mem_wdata          = '0;
        mem_raddr          = {r_ch, cur_newest};
        ch_clear           = 1'b0;
        ch_gap             = 1'b0;
        ch_push            = 1'b0;
        ch_set_sec         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res   = '0;
                n_state = S_DONE;
                if (r_item.req_type == REQ_CLEAR) begin
                    ch_clear = 1'b1;
                end else if (r_ch_ok) begin
                    case (r_item.req_type)
                        REQ_EVENT: begin
                            o_div_req.start = 1'b1;
                            n_state         = S_DIV;
                        end
                        REQ_READ: begin
                            n_res.history_length = LEN_W'(cur_held);
                            if (rd_hit) begin
                                mem_raddr = {r_ch, SLOT_W'(rd_calc)};
                                n_state   = S_READ;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_sec   = i_div_rsp.quotient;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                ch_set_sec = 1'b1;
                if (r_known[r_ch] && r_sec == r_cur[r_ch] && cur_held != '0) begin
                    n_state = S_INCRD;
                end else if (r_known[r_ch] && r_sec > r_cur[r_ch]) begin
                    if (diff > QUO_W'(HISTORY_DEPTH)) begin
                        ch_gap  = 1'b1;
                        n_state = S_PUSH;
                    end else begin
                        n_fill  = SLOT_W'(diff - 1'b1);
                        n_state = S_FILL;
                    end
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_FILL: begin
                if (r_fill == '0) begin
                    n_state = S_PUSH;
                end else begin
                    ch_push = 1'b1;
                    mem_we  = 1'b1;
                    n_fill  = r_fill - 1'b1;
                end
            end
            S_PUSH: begin
                ch_push              = 1'b1;
                mem_we               = 1'b1;
                mem_wdata            = COUNT_W'(1);
                n_res.count          = COUNT_W'(1);
                n_res.history_length = LEN_W'(n_held);
                n_res.new_second     = 1'b1;
                n_state              = S_DONE;
            end
            S_INCRD: begin
                mem_we               = 1'b1;
                mem_waddr            = {r_ch, cur_newest};
                mem_wdata            = inc_val;
                n_res.count          = inc_val;
                n_res.history_length = LEN_W'(cur_held);
                n_state              = S_DONE;
            end
            S_READ: begin
                n_res.count       = r_rd_data;
                n_res.entry_valid = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_held_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held[r_ch] <= HELD_W'(HISTORY_DEPTH))
        else $error("held entry count exceeds history depth");

    a_slot_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HELD_W'(r_newest[r_ch]) < HELD_W'(HISTORY_DEPTH))
        else $error("newest slot outside ring");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |=> (r_held[r_ch] != '0))
        else $error("history empty after push");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res.entry_valid && o_res.new_second))
        else $error("read and event flags both set");

endmodule

`default_nettype wire
